FILE: rtl/qass_pkg.sv
// ----------------------------------------------------------------------------
// qass_pkg: shared types and constants for the quote-aware substring search
// Defaults for the top-level parameters, register indexes and the control
// bundle that steps the quote tracker and the prefix cells.
// ----------------------------------------------------------------------------
package qass_pkg;

  localparam int unsigned DEF_MAX_PATTERN_LENGTH = 16;
  localparam int unsigned DEF_POSITION_WIDTH     = 32;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned START_W     = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_QUOTE_AWARE    = 2'd3;

  // Step control: advance on a byte transfer, clear on the final byte.
  typedef struct packed {
    logic en;
    logic clr;
  } qass_ctl_t;

endpackage

FILE: rtl/quote_aware_substring_search.sv
// ----------------------------------------------------------------------------
// quote_aware_substring_search: streaming first-match search with quote skip
// Output: a result is registered on its final byte; via the skid stage if output held.
// Throughput: 1 byte per cycle; input stalls only while output and skid stage are full.
// Reset: synchronous; clears pattern, quote state, cells, position; quote skip enabled.
// ----------------------------------------------------------------------------
module quote_aware_substring_search
  import qass_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_LENGTH = DEF_MAX_PATTERN_LENGTH,
  parameter int unsigned POSITION_WIDTH     = DEF_POSITION_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_last_byte,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_found,
  output logic [START_W-1:0]     out_match_start
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned EW = (PW > START_W) ? PW : START_W;
  localparam int unsigned NC = MAX_PATTERN_LENGTH;

  // Configuration registers.
  logic [63:0]      pattern_low_r;
  logic [63:0]      pattern_high_r;
  logic [LEN_W-1:0] pattern_length_r;
  logic             quote_aware_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= '0;
      quote_aware_r    <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern_low_r    <= cfg_wdata;
        REG_PATTERN_HIGH:   pattern_high_r   <= cfg_wdata;
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[LEN_W-1:0];
        REG_QUOTE_AWARE:    quote_aware_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Step control.
  qass_ctl_t ctl;
  logic      in_xfer;

  assign in_xfer = in_valid & ~in_stall;
  assign ctl.en  = in_xfer;
  assign ctl.clr = in_last_byte;

  // Quote tracking.
  logic allowed;

  qass_quote u_quote (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .text_byte   (in_text_byte),
    .quote_aware (quote_aware_r),
    .allowed     (allowed)
  );

  // Prefix cell chain.
  logic [NC-1:0] cell_nxt;
  logic [NC-1:0] cell_r;
  logic [NC-1:0] cell_prev;
  logic [NC-1:0] len_hit;

  for (genvar j = 0; j < NC; j++) begin : g_cell
    logic [7:0] pat_byte;

    if (j < 8) begin : g_lo
      assign pat_byte = pattern_low_r[8*j +: 8];
    end else begin : g_hi
      assign pat_byte = pattern_high_r[8*(j-8) +: 8];
    end

    if (j == 0) begin : g_head
      assign cell_prev[j] = allowed;
    end else begin : g_link
      assign cell_prev[j] = cell_r[j-1];
    end

    qass_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .prev_hit  (cell_prev[j]),
      .text_byte (in_text_byte),
      .pat_byte  (pat_byte),
      .hit_nxt   (cell_nxt[j]),
      .hit_r     (cell_r[j])
    );

    assign len_hit[j] = cell_nxt[j] & (pattern_length_r == LEN_W'(j + 1));
  end

  // Position and first match.
  logic [PW-1:0] pos_r;
  logic          match_seen_r;
  logic [PW-1:0] first_start_r;
  logic          hit;
  logic [PW-1:0] hit_start;

  assign hit       = (|len_hit) & ~match_seen_r;
  assign hit_start = pos_r - PW'(pattern_length_r - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      match_seen_r  <= 1'b0;
      first_start_r <= '0;
    end else if (in_xfer) begin
      if (in_last_byte) begin
        pos_r         <= '0;
        match_seen_r  <= 1'b0;
        first_start_r <= '0;
      end else begin
        if (pos_r != '1) pos_r <= pos_r + PW'(1);
        if (hit) begin
          match_seen_r  <= 1'b1;
          first_start_r <= hit_start;
        end
      end
    end
  end

  // Result of the string that ends with this byte.
  logic               res_found;
  logic [PW-1:0]      res_pos;
  logic [EW-1:0]      res_ext;
  logic [START_W-1:0] res_start;
  logic               res_valid;

  assign res_found = match_seen_r | hit;
  assign res_pos   = match_seen_r ? first_start_r : (hit ? hit_start : '0);
  assign res_ext   = EW'(res_pos);
  assign res_start = (res_ext > EW'({START_W{1'b1}})) ? {START_W{1'b1}}
                                                      : res_ext[START_W-1:0];
  assign res_valid = in_xfer & in_last_byte;

  // Output register with a skid stage behind it.
  logic               out_valid_r;
  logic               out_found_r;
  logic [START_W-1:0] out_start_r;
  logic               skd_valid_r;
  logic               skd_found_r;
  logic [START_W-1:0] skd_start_r;
  logic               out_free;

  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= skd_valid_r | res_valid;
      skd_valid_r <= 1'b0;
    end else if (res_valid) begin
      skd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_found_r <= skd_valid_r ? skd_found_r : res_found;
      out_start_r <= skd_valid_r ? skd_start_r : res_start;
    end
    if (!out_free && res_valid) begin
      skd_found_r <= res_found;
      skd_start_r <= res_start;
    end
  end

  assign in_stall        = skd_valid_r;
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_start = out_start_r;

`ifndef SYNTHESIS
  // The skid stage only fills behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  // Every final byte returns the per-string state to its start.
  a_string_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last_byte) |=> (pos_r == '0) && !match_seen_r && (cell_r == '0))
    else $error("per-string state not cleared after the final byte");

  // A recorded match cannot start beyond the current position.
  a_start_order: assert property (@(posedge clk) disable iff (!rst_n)
    match_seen_r |-> (first_start_r <= pos_r))
    else $error("recorded match start lies beyond the byte position");

  // Once found, the first match start stays fixed until the string ends.
  a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (match_seen_r && !(in_xfer && in_last_byte)) |=> $stable(first_start_r))
    else $error("first match start changed after a match was recorded");
`endif

endmodule

FILE: rtl/qass_quote.sv
// ----------------------------------------------------------------------------
// qass_quote: quote state tracker
// Follows double and single quoted runs and decides whether the current byte
// may start a match.
// ----------------------------------------------------------------------------
module qass_quote
  import qass_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  qass_ctl_t ctl,
  input  logic [7:0] text_byte,
  input  logic      quote_aware,
  output logic      allowed
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_DOUBLE = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;

  localparam logic [7:0] DQUOTE = 8'h22;
  localparam logic [7:0] SQUOTE = 8'h27;

  logic [1:0] mode_r;
  logic [1:0] mode_nxt;
  logic       code_ok;

  always_comb begin
    mode_nxt = mode_r;
    code_ok  = 1'b0;
    unique case (mode_r)
      MODE_NORMAL: begin
        code_ok = 1'b1;
        if (text_byte == DQUOTE) begin
          mode_nxt = MODE_DOUBLE;
          code_ok  = 1'b0;
        end else if (text_byte == SQUOTE) begin
          mode_nxt = MODE_SINGLE;
          code_ok  = 1'b0;
        end
      end
      MODE_DOUBLE: begin
        if (text_byte == DQUOTE) mode_nxt = MODE_NORMAL;
      end
      MODE_SINGLE: begin
        if (text_byte == SQUOTE) mode_nxt = MODE_NORMAL;
      end
      default: begin
        mode_nxt = MODE_NORMAL;
      end
    endcase
  end

  assign allowed = code_ok | ~quote_aware;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (ctl.en) begin
      mode_r <= ctl.clr ? MODE_NORMAL : mode_nxt;
    end
  end

endmodule

FILE: rtl/qass_cell.sv
// ----------------------------------------------------------------------------
// qass_cell: one prefix cell of the search chain
// Cell j remembers whether pattern bytes 0..j matched the text ending at the
// previous byte, starting at an allowed position.
// ----------------------------------------------------------------------------
module qass_cell
  import qass_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  qass_ctl_t  ctl,
  input  logic       prev_hit,
  input  logic [7:0] text_byte,
  input  logic [7:0] pat_byte,
  output logic       hit_nxt,
  output logic       hit_r
);

  assign hit_nxt = prev_hit & (text_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.en) begin
      hit_r <= ctl.clr ? 1'b0 : hit_nxt;
    end
  end

endmodule
